@@ rtl/scp_pkg.sv @@
package scp_pkg;

	// Fixed word widths
	localparam int DATA_W        = 32;
	localparam int REST_W        = 31;
	localparam int SCP_FRAC_BITS = 16;
	// Quotient bits of one displacement (displacement stays below 2^33)
	localparam int QUO_W         = 34;
	// Sum width for point plus signed displacement
	localparam int SUM_W         = QUO_W + 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = REST_W;

	localparam logic [REST_W-1:0] REST_RESET = REST_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REST_LEN = 2'd0,
		CFG_A_FIXED  = 2'd1,
		CFG_B_FIXED  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] a_x;
		logic signed [DATA_W-1:0] a_y;
		logic signed [DATA_W-1:0] a_z;
		logic signed [DATA_W-1:0] b_x;
		logic signed [DATA_W-1:0] b_y;
		logic signed [DATA_W-1:0] b_z;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pa_x;
		logic signed [DATA_W-1:0] pa_y;
		logic signed [DATA_W-1:0] pa_z;
		logic signed [DATA_W-1:0] pb_x;
		logic signed [DATA_W-1:0] pb_y;
		logic signed [DATA_W-1:0] pb_z;
	} out_word_t;

	// Clamp a widened sum to the signed 32-bit range
	function automatic logic [DATA_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi_lim;
		logic signed [SUM_W-1:0] lo_lim;
		hi_lim = SUM_W'(2147483647);
		lo_lim = -SUM_W'(64'sd2147483648);
		if (v > hi_lim)
			sat_word = {1'b0, {(DATA_W-1){1'b1}}};
		else if (v < lo_lim)
			sat_word = {1'b1, {(DATA_W-1){1'b0}}};
		else
			sat_word = v[DATA_W-1:0];
	endfunction

endpackage

@@ rtl/spring_constraint_projection.sv @@
// Spring constraint projection, one spring (two 3D endpoints) per word.
//
// Input channel in_valid/in_ready/in_data carries endpoints a and b in signed
// fixed point with FRAC_BITS fraction bits. Output channel out_valid/out_ready/
// out_data returns the projected endpoints, saturated to 32 bits, in order.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 rest length,
// 1 end a pinned, 2 end b pinned) in the same cycle; other indexes are ignored.
// Write it only while no word is in flight.
//
// Throughput is one word per cycle unless the receiver stalls the output.
// The pipeline has three setup stages (difference, squares, sum),
// 33 + FRAC_BITS square-root stages (one root bit each), two multiply/add
// stages, 34 divider stages (one quotient bit each), and the output register.
//
// Reset clears all valid bits and loads rest length 1.0 with both ends free.
// When the receiver holds out_ready low with a word waiting, the whole pipeline
// freezes and in_ready drops; nothing is lost or repeated.
module spring_constraint_projection
	import scp_pkg::*;
#(
	parameter int FRAC_BITS = SCP_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int RW  = 33 + FRAC_BITS;   // root width
	localparam int XW  = 2 * RW;           // radicand width
	localparam int DW  = RW + 1;           // divisor base width
	localparam int DDW = DW + 1;           // doubled divisor width
	localparam int PW  = RW + 32;          // product width
	localparam int NW  = RW + 34;          // numerator width
	localparam int NS  = 5 + RW + QUO_W;   // sideband line length

	typedef struct packed {
		in_word_t                     pt;
		logic [2:0]                   neg;
		logic [2:0][DATA_W-1:0]       mag;
	} side_t;

	// Configuration registers
	logic [REST_W-1:0] rest_len_q;
	logic              a_fixed_q;
	logic              b_fixed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_len_q <= REST_RESET;
			a_fixed_q  <= 1'b0;
			b_fixed_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_REST_LEN: rest_len_q <= cfg_wdata;
				CFG_A_FIXED:  a_fixed_q  <= cfg_wdata[0];
				CFG_B_FIXED:  b_fixed_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Global advance: move when output is empty or being taken
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: difference, sign and magnitude per axis
	logic [2:0][DATA_W-1:0] a_in;
	logic [2:0][DATA_W-1:0] b_in;
	logic [2:0]             neg_c;
	logic [2:0][DATA_W-1:0] mag_c;

	assign a_in = {in_data.a_z, in_data.a_y, in_data.a_x};
	assign b_in = {in_data.b_z, in_data.b_y, in_data.b_x};

	always_comb begin
		logic [DATA_W:0] diff;
		logic [DATA_W:0] ndiff;
		for (int i = 0; i < 3; i++) begin
			diff     = {b_in[i][DATA_W-1], b_in[i]} - {a_in[i][DATA_W-1], a_in[i]};
			ndiff    = -diff;
			neg_c[i] = diff[DATA_W];
			mag_c[i] = diff[DATA_W] ? ndiff[DATA_W-1:0] : diff[DATA_W-1:0];
		end
	end

	// Sideband and valid line
	side_t side_q [NS];
	logic  v_q    [NS];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= '{pt: in_data, neg: neg_c, mag: mag_c};
			for (int j = 1; j < NS; j++)
				side_q[j] <= side_q[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NS; j++)
				v_q[j] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int j = 1; j < NS; j++)
				v_q[j] <= v_q[j-1];
		end
	end

	// Stage 2: squares
	logic [2:0][2*DATA_W-1:0] sq_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= side_q[0].mag[i] * side_q[0].mag[i];
		end
	end

	// Stage 3: squared length, scaled by 2^(2F)
	logic [XW-1:0] x_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= {(XW-2*FRAC_BITS)'(sq_s2[0]) + (XW-2*FRAC_BITS)'(sq_s2[1])
				+ (XW-2*FRAC_BITS)'(sq_s2[2]), {(2*FRAC_BITS){1'b0}}};
		end
	end

	// Length
	logic [RW-1:0] lf;

	scp_sqrt #(.RW(RW)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.x    (x_s3),
		.root (lf)
	);

	// M1: length error, divisor select, partial products
	logic [RW-1:0] restf;
	logic          pin;
	logic          lt;
	logic [RW-1:0] smag;

	assign restf = {{(RW-REST_W-FRAC_BITS){1'b0}}, rest_len_q, {FRAC_BITS{1'b0}}};
	assign pin   = a_fixed_q ^ b_fixed_q;
	assign lt    = (lf < restf);
	assign smag  = pin ? restf : (lt ? (restf - lf) : (lf - restf));

	logic [2:0][63:0]   pl_m1;
	logic [2:0][RW-1:0] ph_m1;
	logic [DW-1:0]      den_m1;
	logic               sneg_m1;

	always_ff @(posedge clk) begin
		if (en) begin
			den_m1  <= pin ? {1'b0, lf} : {lf, 1'b0};
			sneg_m1 <= !pin && lt;
			for (int i = 0; i < 3; i++) begin
				pl_m1[i] <= smag[31:0] * side_q[2+RW].mag[i];
				ph_m1[i] <= smag[RW-1:32] * side_q[2+RW].mag[i];
			end
		end
	end

	// M2: rounding numerator 2*s*|d| + den, divisor 2*den
	logic [2:0][NW-1:0] num_m2;
	logic [DDW-1:0]     dvs_m2;
	logic [2:0]         neg_m2;

	always_ff @(posedge clk) begin
		logic [PW-1:0] prod;
		if (en) begin
			// zero length means zero numerator; any nonzero divisor gives zero
			dvs_m2 <= (den_m1 == '0) ? {DDW{1'b1}} : {den_m1, 1'b0};
			for (int i = 0; i < 3; i++) begin
				prod      = {ph_m1[i], 32'b0} + PW'(pl_m1[i]);
				num_m2[i] <= NW'({prod, 1'b0}) + NW'(den_m1);
				neg_m2[i] <= sneg_m1 ^ side_q[3+RW].neg[i];
			end
		end
	end

	// Dividers, one per axis
	logic signed [2:0][QUO_W:0] h;

	for (genvar i = 0; i < 3; i++) begin : g_div
		scp_div #(.NW(NW), .DDW(DDW), .QW(QUO_W)) u_div (
			.clk (clk),
			.en  (en),
			.num (num_m2[i]),
			.dvs (dvs_m2),
			.neg (neg_m2[i]),
			.quo (h[i])
		);
	end

	// Output stage: apply displacement per pinning, saturate
	logic [2:0][DATA_W-1:0] pa_c;
	logic [2:0][DATA_W-1:0] pb_c;

	always_comb begin
		logic signed [SUM_W-1:0] ae;
		logic signed [SUM_W-1:0] be;
		logic signed [SUM_W-1:0] he;
		logic [DATA_W-1:0]       av;
		logic [DATA_W-1:0]       bv;
		for (int i = 0; i < 3; i++) begin
			unique case (i)
				0: begin
					av = side_q[NS-1].pt.a_x;
					bv = side_q[NS-1].pt.b_x;
				end
				1: begin
					av = side_q[NS-1].pt.a_y;
					bv = side_q[NS-1].pt.b_y;
				end
				default: begin
					av = side_q[NS-1].pt.a_z;
					bv = side_q[NS-1].pt.b_z;
				end
			endcase
			ae = {{(SUM_W-DATA_W){av[DATA_W-1]}}, av};
			be = {{(SUM_W-DATA_W){bv[DATA_W-1]}}, bv};
			he = {h[i][QUO_W], h[i]};
			pa_c[i] = a_fixed_q ? av : (b_fixed_q ? sat_word(be - he) : sat_word(ae + he));
			pb_c[i] = b_fixed_q ? bv : (a_fixed_q ? sat_word(ae + he) : sat_word(be - he));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= '{pa_x: pa_c[0], pa_y: pa_c[1], pa_z: pa_c[2],
				pb_x: pb_c[0], pb_y: pb_c[1], pb_z: pb_c[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v_q[NS-1];
	end

endmodule

@@ rtl/scp_sqrt.sv @@
// Pipelined restoring square root: one root bit per stage, RW stages.
module scp_sqrt #(
	parameter int RW = 49
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] x,
	output logic [RW-1:0]   root
);

	logic [RW+1:0]   rem_q  [RW];
	logic [RW-1:0]   root_q [RW];
	logic [2*RW-1:0] x_q    [RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RW+1:0]   rem_in;
		logic [RW+1:0]   rem_sh;
		logic [RW+1:0]   trial;
		logic [RW-1:0]   root_in;
		logic [2*RW-1:0] x_in;
		logic            take;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = x;
		end else begin : g_next
			assign rem_in  = rem_q[i-1];
			assign root_in = root_q[i-1];
			assign x_in    = x_q[i-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign rem_sh = {rem_in[RW-1:0], x_in[2*RW-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign take   = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[i] <= {root_in[RW-2:0], take};
			end
		end

		if (i < RW-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i] <= take ? (rem_sh - trial) : rem_sh;
					x_q[i]   <= {x_in[2*RW-3:0], 2'b00};
				end
			end
		end else begin : g_last
			assign rem_q[i] = '0;
			assign x_q[i]   = '0;
		end
	end

	assign root = root_q[RW-1];

endmodule

@@ rtl/scp_div.sv @@
// Pipelined restoring divider with sign: one quotient bit per stage.
module scp_div #(
	parameter int NW  = 83,
	parameter int DDW = 51,
	parameter int QW  = 34
) (
	input  logic               clk,
	input  logic               en,
	input  logic [NW-1:0]      num,
	input  logic [DDW-1:0]     dvs,
	input  logic               neg,
	output logic signed [QW:0] quo
);

	logic [DDW-1:0] rem_q [QW];
	logic [QW-1:0]  nlo_q [QW];
	logic [QW-1:0]  q_q   [QW];
	logic [DDW-1:0] d_q   [QW];
	logic           neg_q [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [DDW-1:0] rem_in;
		logic [QW-1:0]  nlo_in;
		logic [QW-1:0]  q_in;
		logic [DDW-1:0] d_in;
		logic           neg_in;
		logic [DDW:0]   rem_sh;
		logic           ge;

		if (j == 0) begin : g_first
			// upper numerator bits are already below the divisor
			assign rem_in = {{(DDW-NW+QW){1'b0}}, num[NW-1:QW]};
			assign nlo_in = num[QW-1:0];
			assign q_in   = '0;
			assign d_in   = dvs;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign nlo_in = nlo_q[j-1];
			assign q_in   = q_q[j-1];
			assign d_in   = d_q[j-1];
			assign neg_in = neg_q[j-1];
		end

		assign rem_sh = {rem_in, nlo_in[QW-1]};
		assign ge     = (rem_sh >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			if (en) begin
				q_q[j]   <= {q_in[QW-2:0], ge};
				neg_q[j] <= neg_in;
			end
		end

		if (j < QW-1) begin : g_carry
			logic [DDW:0] rem_nx;
			assign rem_nx = ge ? (rem_sh - {1'b0, d_in}) : rem_sh;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= rem_nx[DDW-1:0];
					nlo_q[j] <= {nlo_in[QW-2:0], 1'b0};
					d_q[j]   <= d_in;
				end
			end
		end else begin : g_last
			assign rem_q[j] = '0;
			assign nlo_q[j] = '0;
			assign d_q[j]   = '0;
		end
	end

	// apply sign of the displacement
	assign quo = neg_q[QW-1] ? -$signed({1'b0, q_q[QW-1]}) : $signed({1'b0, q_q[QW-1]});

endmodule

@@ rtl/scp_chk.sv @@
// Port-level checks for the spring projection block.
module scp_chk
	import scp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// a waiting word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// a stalled output freezes the pipeline, so no new word enters
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	// an empty output register never holds off the sender
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule

bind spring_constraint_projection scp_chk u_scp_chk (.*);

@@ tb/tb_spring_constraint_projection.sv @@
module tb_spring_constraint_projection
	import scp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] SPARE_IDX = 2'd3;
	localparam int PIPE_LAT = 73 + SCP_FRAC_BITS;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_word_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	spring_constraint_projection uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// local copy of the registers
	logic [REST_W-1:0] rest_len_q;
	logic              a_pinned;
	logic              b_pinned;

	in_word_t  send_q[$];
	out_word_t proj_q[$];
	int        errors;
	int        words_sent;
	int        words_seen;

	// append one spring to the send queue
	task automatic queue_spring(input in_word_t w);
		send_q = {send_q, w};
	endtask

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// integer square root of a wide value, one bit per step
	function automatic logic [63:0] root_len(input logic [127:0] x);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int bit_i = 60; bit_i >= 0; bit_i--) begin
			c = r | (64'd1 << bit_i);
			if ({64'd0, c} * {64'd0, c} <= x)
				r = c;
		end
		return r;
	endfunction

	// round(smag * |d| / den), sign of smag times sign of d
	function automatic longint move_len(input logic [63:0] smag, input bit neg,
			input longint d, input logic [63:0] den);
		logic [63:0]  dm;
		logic [127:0] num;
		logic [127:0] quo;
		longint       q;
		dm = d < 0 ? 64'(-d) : 64'(d);
		if (den == 0)
			return 0;
		num = ({64'd0, smag} * {64'd0, dm}) << 1;
		quo = (num + {64'd0, den}) / ({64'd0, den} << 1);
		q = longint'(quo[63:0]);
		return (neg != (d < 0)) ? -q : q;
	endfunction

	function automatic logic [DATA_W-1:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// projected endpoints for one spring under the current registers
	function automatic out_word_t project_spring(input in_word_t w);
		longint       a[3], b[3], d[3], pa[3], pb[3];
		logic [127:0] sq;
		logic [63:0]  lf, restf, off, dmag;
		longint       h;
		bit           neg;
		out_word_t    r;
		a[0] = w.a_x; a[1] = w.a_y; a[2] = w.a_z;
		b[0] = w.b_x; b[1] = w.b_y; b[2] = w.b_z;
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			d[i] = b[i] - a[i];
			dmag = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
			sq += {64'd0, dmag} * {64'd0, dmag};
		end
		lf = root_len(sq << (2 * SCP_FRAC_BITS));
		restf = {33'd0, rest_len_q} << SCP_FRAC_BITS;
		neg = lf < restf;
		off = neg ? restf - lf : lf - restf;
		for (int i = 0; i < 3; i++) begin
			if (a_pinned && b_pinned) begin
				pa[i] = a[i];
				pb[i] = b[i];
			end else if (a_pinned) begin
				pa[i] = a[i];
				pb[i] = a[i] + move_len(restf, 1'b0, d[i], lf);
			end else if (b_pinned) begin
				pb[i] = b[i];
				pa[i] = b[i] - move_len(restf, 1'b0, d[i], lf);
			end else begin
				h = move_len(off, neg, d[i], lf << 1);
				pa[i] = a[i] + h;
				pb[i] = b[i] - h;
			end
		end
		r.pa_x = clamp32(pa[0]); r.pa_y = clamp32(pa[1]); r.pa_z = clamp32(pa[2]);
		r.pb_x = clamp32(pb[0]); r.pb_y = clamp32(pb[1]); r.pb_z = clamp32(pb[2]);
		return r;
	endfunction

	// driver: bursts and gaps, holds word until accepted
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_data    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready) begin
				proj_q = {proj_q, project_spring(in_data)};
				words_sent++;
			end
			if (in_valid && !in_ready) begin
				// keep offering
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (send_q.size() > 0) begin
				in_valid <= 1'b1;
				in_data  <= send_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: stall pattern, long holds, field compare
	int  hold_left;
	int  stall_mode;
	int  mode_left;
	bit  hold1_done;
	bit  hold2_done;
	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			hold_left  <= 0;
			stall_mode <= 0;
			mode_left  <= 0;
			hold1_done <= 1'b0;
			hold2_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				words_seen++;
				if (proj_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h", $time, out_data);
				end else begin
					exp_w = proj_q.pop_front();
					for (int i = 0; i < 6; i++)
						if (out_data[32*i +: 32] !== exp_w[32*i +: 32]) begin
							errors++;
							$display("%0t: field %0d expected %h actual %h", $time,
								5 - i, exp_w[32*i +: 32], out_data[32*i +: 32]);
						end
				end
			end
			if (!hold1_done && words_sent >= 400) begin
				hold1_done <= 1'b1;
				hold_left  <= 400;
				out_ready  <= 1'b0;
			end else if (!hold2_done && words_sent >= 900) begin
				hold2_done <= 1'b1;
				hold_left  <= 300;
				out_ready  <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				if (mode_left <= 0) begin
					stall_mode <= $urandom_range(0, 3);
					mode_left  <= $urandom_range(20, 200);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_REST_LEN: rest_len_q = val;
		CFG_A_FIXED:  a_pinned = val[0];
		CFG_B_FIXED:  b_pinned = val[0];
		default: ;
		endcase
	endtask

	task automatic drain();
		while (send_q.size() > 0 || in_valid || proj_q.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 20) @(posedge clk);
	endtask

	function automatic in_word_t spring_word(input logic [31:0] ax, ay, az, bx, by, bz);
		in_word_t w;
		w.a_x = ax; w.a_y = ay; w.a_z = az;
		w.b_x = bx; w.b_y = by; w.b_z = bz;
		return w;
	endfunction

	// random spring: mostly small spread between the ends, some coincident, the rest full range
	function automatic in_word_t rand_spring();
		in_word_t w;
		int sel;
		sel = $urandom_range(0, 19);
		w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (sel < 12) begin
			w.a_x = $signed($urandom) >>> $urandom_range(4, 12);
			w.a_y = $signed($urandom) >>> $urandom_range(4, 12);
			w.a_z = $signed($urandom) >>> $urandom_range(4, 12);
			w.b_x = w.a_x + ($signed($urandom) >>> $urandom_range(10, 20));
			w.b_y = w.a_y + ($signed($urandom) >>> $urandom_range(10, 20));
			w.b_z = w.a_z + ($signed($urandom) >>> $urandom_range(10, 20));
		end else if (sel == 12) begin
			w.b_x = w.a_x; w.b_y = w.a_y; w.b_z = w.a_z;
		end
		return w;
	endfunction

	task automatic run_rand(input int count);
		repeat (count) queue_spring(rand_spring());
		drain();
	endtask

	int phase_cnt;
	initial begin
		logic [CFG_DATA_W-1:0] rv;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = CFG_REST_LEN;
		cfg_wdata = '0;
		errors = 0; words_sent = 0; words_seen = 0;
		rest_len_q = REST_RESET;
		a_pinned = 1'b0;
		b_pinned = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed, reset values: zero, coincident, extremes, overflow
		queue_spring(spring_word(0, 0, 0, 0, 0, 0));
		queue_spring(spring_word(32'h10000, 5, -7, 32'h10000, 5, -7));
		queue_spring(spring_word(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		queue_spring(spring_word(32'h7fffffff, 0, 32'h80000000,
			32'h80000000, 0, 32'h7fffffff));
		queue_spring(spring_word(0, 0, 0, 32'h20000, 0, 0));
		queue_spring(spring_word(0, 0, 0, 32'h8000, 0, 0));
		queue_spring(spring_word(0, 0, 0, 0, 0, 1));
		queue_spring(spring_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7ffffff0, 32'h7ffffff0, 32'h7ffffff0));
		drain();
		// directed, pinned ends and rest length extremes
		write_reg(CFG_REST_LEN, 31'h7fffffff);
		write_reg(CFG_A_FIXED, 31'h7ffffffe | 31'd1);
		queue_spring(spring_word(0, 0, 0, 32'h10000, 0, 0));
		queue_spring(spring_word(32'h80000000, 0, 0, 32'h80000001, 1, 1));
		queue_spring(spring_word(3, 3, 3, 3, 3, 3));
		drain();
		write_reg(CFG_A_FIXED, 31'h2aaaaaaa);
		write_reg(CFG_B_FIXED, 31'h55555555);
		queue_spring(spring_word(0, 0, 0, 32'h10000, 0, 0));
		queue_spring(spring_word(32'h7fffffff, 0, 0, 32'h7ffffffe, 0, 0));
		drain();
		write_reg(CFG_A_FIXED, 31'd1);
		queue_spring(spring_word(1, 2, 3, 32'h40000, 32'h80000000, 9));
		queue_spring(spring_word(32'h80000000, 32'h7fffffff, 0, 0, 0, 0));
		drain();
		write_reg(CFG_REST_LEN, 31'd0);
		write_reg(CFG_A_FIXED, 31'd0);
		write_reg(CFG_B_FIXED, 31'd0);
		write_reg(SPARE_IDX, 31'h1234567);
		queue_spring(spring_word(0, 0, 0, 32'h30000, 32'h40000, 0));
		queue_spring(spring_word(32'h80000000, 0, 0, 32'h7fffffff, 0, 0));
		drain();

		// random phases over register settings
		for (phase_cnt = 0; phase_cnt < 8; phase_cnt++) begin
			case (phase_cnt % 4)
			0: rv = 31'($urandom_range(0, 32'h40000));
			1: rv = 31'h7fffffff;
			2: rv = '0;
			default: rv = 31'($urandom);
			endcase
			write_reg(CFG_REST_LEN, rv);
			write_reg(CFG_A_FIXED, {30'($urandom), phase_cnt[1]});
			write_reg(CFG_B_FIXED, {30'($urandom), phase_cnt[0] ^ phase_cnt[2]});
			run_rand(140);
		end

		$display("Covered %0d springs, %0d results, all pin combinations and rest extremes.",
			words_sent, words_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#3ms;
		$display("Timeout after %0d springs, %0d results.", words_sent, words_seen);
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/scp_pkg.sv
rtl/scp_sqrt.sv
rtl/scp_div.sv
rtl/spring_constraint_projection.sv
rtl/scp_chk.sv
tb/tb_spring_constraint_projection.sv
